FILE: hw/rtl/ids_pkg.sv
package ids_pkg;

  localparam int FRAC_BITS     = 15;
  localparam int CORDIC_STAGES = 16;

  localparam int SQ_W      = 2 * FRAC_BITS + 1;
  localparam int SQ_STEPS  = FRAC_BITS + 1;
  localparam int SQ_STAGES = (SQ_STEPS + 1) / 2;
  localparam int ROOT_W    = FRAC_BITS + 1;
  localparam int XY_W      = FRAC_BITS + 3;
  localparam int ANG_W     = 34;
  localparam int CD_STAGES = (CORDIC_STAGES + 1) / 2;
  localparam int ZZ_W      = 31;

  localparam logic [31:0] GAIN_COMP = 32'd2608131496;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd1073741824, 32'd633866812, 32'd334917815, 32'd170009512,
    32'd85334662,   32'd42708931,  32'd21359677,  32'd10680490,
    32'd5340327,    32'd2670173,   32'd1335088,   32'd667544,
    32'd333772,     32'd166886,    32'd83443,     32'd41722,
    32'd20861,      32'd10430,     32'd5215,      32'd2608,
    32'd1304,       32'd652,       32'd326,       32'd163,
    32'd81,         32'd41,        32'd20,        32'd10,
    32'd5,          32'd3,         32'd1,         32'd1
  };

  typedef struct packed {
    logic signed [15:0]      z;
    logic                    flip;
    logic signed [ANG_W-1:0] ang;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [SQ_W-1:0] rad;
  } sq_in_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] root;
  } rt_t;

  typedef struct packed {
    side_t                  side;
    logic signed [XY_W-1:0] x0;
  } cd_in_t;

  typedef struct packed {
    logic signed [15:0]     z;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } cd_out_t;

endpackage

FILE: hw/rtl/ids_if.sv
interface ids_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] rand_z;
  logic [15:0] rand_angle;

  modport source (output valid, rand_z, rand_angle, input ready);
  modport sink (input valid, rand_z, rand_angle, output ready);
endinterface

interface ids_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

FILE: hw/rtl/ids_sqrt.sv
module ids_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ids_pkg::sq_in_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ids_pkg::rt_t    out_data_o
);

  localparam int NS = ids_pkg::SQ_STAGES;
  localparam int W  = ids_pkg::SQ_W;

  typedef struct packed {
    ids_pkg::side_t side;
    logic [W-1:0]   rem;
    logic [W:0]     res;
  } sq_st_t;

  sq_st_t src   [NS];
  sq_st_t st_d  [NS];
  sq_st_t st_q  [NS];
  logic   v_q   [NS];
  logic   adv   [NS];

  always_comb begin
    src[0].side = in_data_i.side;
    src[0].rem  = in_data_i.rad;
    src[0].res  = '0;
    for (int s = 1; s < NS; s++) begin
      src[s] = st_q[s-1];
    end
  end

  // two result bits per stage
  always_comb begin
    sq_st_t     cur;
    logic [W:0] bitv;
    logic [W:0] t;
    for (int s = 0; s < NS; s++) begin
      cur = src[s];
      for (int k = 0; k < 2; k++) begin
        if (2 * s + k < ids_pkg::SQ_STEPS) begin
          bitv = (W + 1)'(1) << (2 * (ids_pkg::SQ_STEPS - 1 - (2 * s + k)));
          t    = cur.res + bitv;
          if ((W + 1)'(cur.rem) >= t) begin
            cur.rem = cur.rem - W'(t);
            cur.res = (cur.res >> 1) + bitv;
          end else begin
            cur.res = cur.res >> 1;
          end
        end
      end
      st_d[s] = cur;
    end
  end

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      adv[s] = !v_q[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '{default: 1'b0};
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      if (adv[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign in_ready_o      = adv[0];
  assign out_valid_o     = v_q[NS-1];
  assign out_data_o.side = st_q[NS-1].side;
  assign out_data_o.root = ids_pkg::ROOT_W'(st_q[NS-1].res);

endmodule

FILE: hw/rtl/ids_gain.sv
module ids_gain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ids_pkg::rt_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ids_pkg::cd_in_t out_data_o
);

  localparam int PW = ids_pkg::ROOT_W + 32;

  ids_pkg::side_t side0_q;
  logic [PW-1:0]  prod_q;
  logic           v0_q;
  logic           v1_q;
  logic           adv0;
  logic           adv1;

  ids_pkg::cd_in_t       res_d;
  ids_pkg::cd_in_t       res_q;
  logic [PW-1:0]         sum;
  logic [ids_pkg::ROOT_W-1:0] rs;
  logic signed [ids_pkg::XY_W-1:0] rs_s;

  // round the gain-compensated radius, then negate it when the side's flip bit is set
  always_comb begin
    sum        = prod_q + (PW'(1) << 31);
    rs         = sum[PW-1:32];
    rs_s       = signed'(ids_pkg::XY_W'(rs));
    res_d.side = side0_q;
    res_d.x0   = side0_q.flip ? -rs_s : rs_s;
  end

  assign adv1 = !v1_q || out_ready_i;
  assign adv0 = !v0_q || adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (adv0) begin
        v0_q <= in_valid_i;
      end
      if (adv1) begin
        v1_q <= v0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      side0_q <= in_data_i.side;
      prod_q  <= PW'(in_data_i.root) * PW'(ids_pkg::GAIN_COMP);
    end
    if (adv1) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = adv0;
  assign out_valid_o = v1_q;
  assign out_data_o  = res_q;

endmodule

FILE: hw/rtl/ids_cordic.sv
module ids_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ids_pkg::cd_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ids_pkg::cd_out_t out_data_o
);

  localparam int NS = ids_pkg::CD_STAGES;
  localparam int XW = ids_pkg::XY_W;
  localparam int AW = ids_pkg::ANG_W;

  typedef struct packed {
    logic signed [15:0]   z;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] a;
  } cd_st_t;

  cd_st_t src  [NS];
  cd_st_t st_d [NS];
  cd_st_t st_q [NS];
  logic   v_q  [NS];
  logic   adv  [NS];

  always_comb begin
    src[0].z = in_data_i.side.z;
    src[0].x = in_data_i.x0;
    src[0].y = '0;
    src[0].a = in_data_i.side.ang;
    for (int s = 1; s < NS; s++) begin
      src[s] = st_q[s-1];
    end
  end

  // two micro-rotations per stage
  always_comb begin
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] a;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [AW-1:0] at;
    for (int s = 0; s < NS; s++) begin
      x = src[s].x;
      y = src[s].y;
      a = src[s].a;
      for (int k = 0; k < 2; k++) begin
        if (2 * s + k < ids_pkg::CORDIC_STAGES) begin
          dx = y >>> (2 * s + k);
          dy = x >>> (2 * s + k);
          at = signed'(AW'(ids_pkg::ATAN_TAB[2 * s + k]));
          if (a >= 0) begin
            x = x - dx;
            y = y + dy;
            a = a - at;
          end else begin
            x = x + dx;
            y = y - dy;
            a = a + at;
          end
        end
      end
      st_d[s].z = src[s].z;
      st_d[s].x = x;
      st_d[s].y = y;
      st_d[s].a = a;
    end
  end

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      adv[s] = !v_q[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '{default: 1'b0};
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      if (adv[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign in_ready_o   = adv[0];
  assign out_valid_o  = v_q[NS-1];
  assign out_data_o.z = st_q[NS-1].z;
  assign out_data_o.x = st_q[NS-1].x;
  assign out_data_o.y = st_q[NS-1].y;

endmodule

FILE: hw/rtl/isotropic_direction_sampler_top.sv
// Isotropic direction sampler: each input transaction (two uniform 16-bit words) yields one
// unit vector uniform on the sphere as signed Q1.15 (dir_x, dir_y, dir_z). The datapath is a
// fully pipelined chain (input multiply, radicand, square root at two bits per stage, gain
// compensation, CORDIC rotator at two micro-rotations per stage, output scaling and
// saturation), so a new transaction is taken every clock cycle unless the output stalls. Back
// pressure from the output stalls only the stages that hold data; empty stages keep filling.
module isotropic_direction_sampler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  ids_in_if.sink      in_i,
  ids_out_if.source   out_o
);

  localparam int AW = ids_pkg::ANG_W;
  localparam int OW = ids_pkg::XY_W + 16;
  localparam int ZW = ids_pkg::ZZ_W;
  localparam logic signed [AW-1:0] ONE_PI = signed'(AW'(1) << 32);

  // input stage
  logic                 v0_q;
  logic signed [15:0]   z0_q;
  logic [ZW-1:0]        zz0_q;
  logic                 flip0_q;
  logic signed [AW-1:0] ang0_q;
  logic                 adv0;

  logic signed [15:0]   zs;
  logic signed [31:0]   zsq;
  logic signed [15:0]   as;
  logic signed [AW-1:0] a_raw;
  logic                 flip_d;
  logic signed [AW-1:0] ang_d;

  always_comb begin
    zs    = signed'({~in_i.rand_z[15], in_i.rand_z[14:0]});
    zsq   = zs * zs;
    as    = signed'({~in_i.rand_angle[15], in_i.rand_angle[14:0]});
    a_raw = AW'(as) <<< 17;
    if (as >= 16'sd16384) begin
      flip_d = 1'b1;
      ang_d  = a_raw - ONE_PI;
    end else if (as < -16'sd16384) begin
      flip_d = 1'b1;
      ang_d  = a_raw + ONE_PI;
    end else begin
      flip_d = 1'b0;
      ang_d  = a_raw;
    end
  end

  // radicand stage
  logic             v1_q;
  ids_pkg::sq_in_t  sq1_q;
  ids_pkg::sq_in_t  sq1_d;
  logic             adv1;
  logic [ZW-1:0]    q30;
  logic             sq_ready;

  assign q30 = (ZW'(1) << 30) - zz0_q;

  generate
    if (ids_pkg::FRAC_BITS >= 15) begin : g_rad_up
      assign sq1_d.rad = ids_pkg::SQ_W'(q30) << (2 * (ids_pkg::FRAC_BITS - 15));
    end else begin : g_rad_dn
      assign sq1_d.rad = ids_pkg::SQ_W'(q30 >> (2 * (15 - ids_pkg::FRAC_BITS)));
    end
  endgenerate

  assign sq1_d.side.z    = z0_q;
  assign sq1_d.side.flip = flip0_q;
  assign sq1_d.side.ang  = ang0_q;

  assign adv1      = !v1_q || sq_ready;
  assign adv0      = !v0_q || adv1;
  assign in_i.ready = adv0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (adv0) begin
        v0_q <= in_i.valid;
      end
      if (adv1) begin
        v1_q <= v0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      z0_q    <= zs;
      zz0_q   <= ZW'(zsq);
      flip0_q <= flip_d;
      ang0_q  <= ang_d;
    end
    if (adv1) begin
      sq1_q <= sq1_d;
    end
  end

  logic             rt_valid;
  logic             rt_ready;
  ids_pkg::rt_t     rt_data;
  logic             gn_valid;
  logic             gn_ready;
  ids_pkg::cd_in_t  gn_data;
  logic             cd_valid;
  logic             cd_ready;
  ids_pkg::cd_out_t cd_data;

  ids_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_ready_o  (sq_ready),
    .in_data_i   (sq1_q),
    .out_valid_o (rt_valid),
    .out_ready_i (rt_ready),
    .out_data_o  (rt_data)
  );

  ids_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rt_valid),
    .in_ready_o  (rt_ready),
    .in_data_i   (rt_data),
    .out_valid_o (gn_valid),
    .out_ready_i (gn_ready),
    .out_data_o  (gn_data)
  );

  ids_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (gn_valid),
    .in_ready_o  (gn_ready),
    .in_data_i   (gn_data),
    .out_valid_o (cd_valid),
    .out_ready_i (cd_ready),
    .out_data_o  (cd_data)
  );

  // output stage: scale to q1.15 and saturate
  function automatic logic signed [15:0] sat16(input logic signed [OW-1:0] v);
    logic signed [15:0] o;
    if (v > OW'(32767)) begin
      o = 16'sh7fff;
    end else if (v < -OW'(32768)) begin
      o = -16'sh8000;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

  logic signed [OW-1:0] sx;
  logic signed [OW-1:0] sy;

  generate
    if (ids_pkg::FRAC_BITS > 15) begin : g_out_dn
      localparam int SH = ids_pkg::FRAC_BITS - 15;
      assign sx = (OW'(cd_data.x) + (OW'(1) <<< (SH - 1))) >>> SH;
      assign sy = (OW'(cd_data.y) + (OW'(1) <<< (SH - 1))) >>> SH;
    end else begin : g_out_up
      assign sx = OW'(cd_data.x) <<< (15 - ids_pkg::FRAC_BITS);
      assign sy = OW'(cd_data.y) <<< (15 - ids_pkg::FRAC_BITS);
    end
  endgenerate

  logic               ov_q;
  logic signed [15:0] dx_q;
  logic signed [15:0] dy_q;
  logic signed [15:0] dz_q;

  assign cd_ready = !ov_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cd_ready) begin
      ov_q <= cd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cd_ready) begin
      dx_q <= sat16(sx);
      dy_q <= sat16(sy);
      dz_q <= cd_data.z;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.dir_x = dx_q;
  assign out_o.dir_y = dy_q;
  assign out_o.dir_z = dz_q;

endmodule
